>>> src/gww_pkg.sv
// Package: shared types and constants for the greedy word wrap block
`timescale 1ns / 1ps

package gww_pkg;

  localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0]  SPACE_BYTE   = 8'h20;
  localparam logic [7:0]  MIN_WIDTH    = 8'd4;
  localparam logic [7:0]  WIDTH_RESET  = 8'd62;
  localparam logic [15:0] POS_BOUND    = 16'hFFFF;

  typedef enum logic {
    ACT_TEXT = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] line_start;
    logic [7:0]  line_length;
    logic        last_line;
    logic        overflow;
  } out_item_t;

endpackage

>>> src/greedy_word_wrap_top.sv
// Top level: greedy word wrap of a byte stream into line records
//
// Input channel in_valid / in_stall / in_data carries one beat per text byte
// (action = text) or an end-of-text marker (action = end). Output channel
// out_valid / out_stall / out_data carries line records: start position,
// length, last-line mark and overflow flag. A beat is taken at a rising edge
// with valid high and stall low.
// The config channel cfg_valid / cfg_ready / cfg_data writes wrap_width
// (widths below 4 act as 4); cfg_ready is always high. Write it only while
// the block is idle.
// An input beat is held in the input register, and its record is then
// registered in the result register; a stall on the output can hold the beat
// in between. Throughput is one beat per cycle while the receiver does not
// stall, set by the single update of the running counters per cycle.
// Newlines, space breaks and hard breaks yield one record; other bytes and
// discarded bytes beyond position 65534 yield none. End of text always
// yields a record and clears the text state.
// Reset (rst, synchronous) empties both registers, clears the text state and
// sets wrap_width to 62. When the receiver stalls, the result register holds
// its beat and the input register fills; in_stall then rises.
`timescale 1ns / 1ps

module greedy_word_wrap_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gww_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gww_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic               in_reg_valid;
  gww_pkg::in_item_t  in_reg;
  logic [7:0]         wrap_width;

  logic [15:0] byte_position;
  logic [15:0] current_line_start;
  logic [15:0] last_space_position;
  logic        space_seen;
  logic [8:0]  column_count;
  logic        overflow_seen;

  logic [15:0] byte_position_next;
  logic [15:0] current_line_start_next;
  logic [15:0] last_space_position_next;
  logic        space_seen_next;
  logic [8:0]  column_count_next;
  logic        overflow_seen_next;

  logic               advance;
  logic               emit;
  gww_pkg::out_item_t result;
  logic [7:0]         width_eff;
  logic [8:0]         col_inc;
  logic               is_space;
  logic [15:0]        space_pos;
  logic [15:0]        len_space;
  logic [15:0]        len_hard;
  logic [15:0]        col_after_space;

  assign cfg_ready = 1'b1;
  assign advance   = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall  = in_reg_valid && !advance;

  always_comb begin
    width_eff = (wrap_width < gww_pkg::MIN_WIDTH) ? gww_pkg::MIN_WIDTH : wrap_width;
    is_space  = (in_reg.text_byte == gww_pkg::SPACE_BYTE);
    col_inc   = column_count + 9'd1;
    space_pos = is_space ? byte_position : last_space_position;
    len_space = space_pos - current_line_start;
    len_hard  = byte_position - current_line_start;
    col_after_space = byte_position - space_pos;

    byte_position_next       = byte_position;
    current_line_start_next  = current_line_start;
    last_space_position_next = last_space_position;
    space_seen_next          = space_seen;
    column_count_next        = column_count;
    overflow_seen_next       = overflow_seen;
    emit                     = 1'b0;
    result.line_start        = current_line_start;
    result.line_length       = column_count[7:0];
    result.last_line         = 1'b0;
    result.overflow          = overflow_seen;

    if (in_reg.action == gww_pkg::ACT_END) begin
      emit                     = 1'b1;
      result.last_line         = 1'b1;
      byte_position_next       = '0;
      current_line_start_next  = '0;
      last_space_position_next = '0;
      space_seen_next          = 1'b0;
      column_count_next        = '0;
      overflow_seen_next       = 1'b0;
    end else if (byte_position >= gww_pkg::POS_BOUND) begin
      overflow_seen_next = 1'b1;
    end else begin
      byte_position_next = byte_position + 16'd1;
      if (in_reg.text_byte == gww_pkg::NEWLINE_BYTE) begin
        emit                    = 1'b1;
        current_line_start_next = byte_position + 16'd1;
        column_count_next       = '0;
        space_seen_next         = 1'b0;
      end else begin
        last_space_position_next = space_pos;
        space_seen_next          = space_seen || is_space;
        column_count_next        = col_inc;
        if (col_inc > {1'b0, width_eff}) begin
          emit            = 1'b1;
          space_seen_next = 1'b0;
          if (space_seen || is_space) begin
            result.line_length      = len_space[7:0];
            current_line_start_next = space_pos + 16'd1;
            column_count_next       = col_after_space[8:0];
          end else begin
            result.line_length      = len_hard[7:0];
            current_line_start_next = byte_position;
            column_count_next       = 9'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid        <= 1'b0;
      out_valid           <= 1'b0;
      wrap_width          <= gww_pkg::WIDTH_RESET;
      byte_position       <= '0;
      current_line_start  <= '0;
      last_space_position <= '0;
      space_seen          <= 1'b0;
      column_count        <= '0;
      overflow_seen       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wrap_width <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        in_reg_valid <= 1'b1;
        in_reg       <= in_data;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end
      if (advance) begin
        out_valid           <= emit;
        out_data            <= result;
        byte_position       <= byte_position_next;
        current_line_start  <= current_line_start_next;
        last_space_position <= last_space_position_next;
        space_seen          <= space_seen_next;
        column_count        <= column_count_next;
        overflow_seen       <= overflow_seen_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
